### src/servo_status_packet_checker_macros.svh
// Assertion macros shared by the servo status packet checker RTL.
`ifndef SERVO_STATUS_PACKET_CHECKER_MACROS_SVH
`define SERVO_STATUS_PACKET_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is high.
`define SSPC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sspc assertion failed");
// Clocked check that also holds during reset.
`define SSPC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sspc assertion failed");
`else
`define SSPC_ASSERT(label, clk, rst, prop)
`define SSPC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### src/sspc_pkg.sv
// Package with types and constants of the servo status packet checker.
`default_nettype none
package sspc_pkg;

   localparam logic [7:0] HEADER_BYTE         = 8'hFF;
   localparam logic [7:0] EXPECTED_ID_RESET   = 8'h00;
   localparam logic [7:0] EXPECTED_LEN_RESET  = 8'h02;

   // Byte positions inside a reply
   localparam logic [8:0] POS_ID      = 9'd2;
   localparam logic [8:0] POS_LENGTH  = 9'd3;
   localparam logic [8:0] POS_PARAM0  = 9'd5;
   localparam logic [8:0] POS_PARAM1  = 9'd6;
   localparam logic [8:0] POS_TRAILER = 9'd3;   // last position = length + this
   localparam logic [8:0] POS_MAX     = 9'd258;

   // Transaction kinds
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   // Configuration register indexes
   localparam logic CSR_EXPECTED_ID     = 1'b0;
   localparam logic CSR_EXPECTED_LENGTH = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_TIMEOUT      = 3'd1,
      STATUS_BAD_HEADER   = 3'd2,
      STATUS_BAD_ID       = 3'd3,
      STATUS_BAD_LENGTH   = 3'd4,
      STATUS_BAD_CHECKSUM = 3'd5
   } status_code_type;

   typedef struct packed {
      logic [7:0] expected_id;
      logic [7:0] expected_length;
   } cfg_type;

   typedef struct packed {
      status_code_type status_code;
      logic [15:0]     reply_value;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_type;

endpackage
`default_nettype wire

### src/sspc_csr.sv
// Configuration registers: expected id and expected length.
`default_nettype none
module sspc_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_write_enable,
   input  wire logic            csr_index,
   input  wire logic [7:0]      csr_write_data,
   output sspc_pkg::cfg_type    cfg
);
   import sspc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_EXPECTED_ID:     cfg_in.expected_id     = csr_write_data;
            CSR_EXPECTED_LENGTH: cfg_in.expected_length = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_id     <= EXPECTED_ID_RESET;
         cfg_ff.expected_length <= EXPECTED_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### src/sspc_parser.sv
// Reply parser: position counter, running sum, sticky error flags, status decision.
`default_nettype none
`include "servo_status_packet_checker_macros.svh"
module sspc_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sspc_pkg::cfg_type  cfg,
   input  wire logic               accept,
   input  wire logic               kind,
   input  wire logic [7:0]         rx_byte,
   output sspc_pkg::result_type    result
);
   import sspc_pkg::*;

   logic [8:0]  pos_ff,    pos_in;
   logic [7:0]  sum_ff,    sum_in;
   logic        hdr_bad_ff, hdr_bad_in;
   logic        id_bad_ff,  id_bad_in;
   logic        len_bad_ff, len_bad_in;
   logic [15:0] value_ff,  value_in;
   logic [8:0]  last_pos;

   assign last_pos = {1'b0, cfg.expected_length} + POS_TRAILER;

   // Advance through the reply and decide the status on its last byte or on a timeout
   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      hdr_bad_in = hdr_bad_ff;
      id_bad_in  = id_bad_ff;
      len_bad_in = len_bad_ff;
      value_in   = value_ff;
      result     = '{valid: 1'b0, payload: '{status_code: STATUS_OK, reply_value: 16'd0}};
      if (accept) begin
         if (kind == KIND_TIMEOUT) begin
            result.valid               = 1'b1;
            result.payload.status_code = STATUS_TIMEOUT;
            pos_in     = 9'd0;
            sum_in     = 8'd0;
            hdr_bad_in = 1'b0;
            id_bad_in  = 1'b0;
            len_bad_in = 1'b0;
            value_in   = 16'd0;
         end else if (pos_ff < last_pos) begin
            if (pos_ff < POS_ID) begin
               if (rx_byte != HEADER_BYTE) begin
                  hdr_bad_in = 1'b1;
               end
            end else begin
               if (pos_ff == POS_ID && rx_byte != cfg.expected_id) begin
                  id_bad_in = 1'b1;
               end
               if (pos_ff == POS_LENGTH && rx_byte != cfg.expected_length) begin
                  len_bad_in = 1'b1;
               end
               if (pos_ff == POS_PARAM0) begin
                  value_in[7:0] = rx_byte;
               end
               if (pos_ff == POS_PARAM1) begin
                  value_in[15:8] = rx_byte;
               end
               sum_in = sum_ff + rx_byte;
            end
            pos_in = pos_ff + 9'd1;
         end else begin
            // Checksum byte: first failing check wins
            result.valid = 1'b1;
            if (hdr_bad_ff) begin
               result.payload.status_code = STATUS_BAD_HEADER;
            end else if (id_bad_ff) begin
               result.payload.status_code = STATUS_BAD_ID;
            end else if (len_bad_ff) begin
               result.payload.status_code = STATUS_BAD_LENGTH;
            end else if (~sum_ff != rx_byte) begin
               result.payload.status_code = STATUS_BAD_CHECKSUM;
            end else begin
               result.payload.status_code = STATUS_OK;
               result.payload.reply_value = value_ff;
            end
            pos_in     = 9'd0;
            sum_in     = 8'd0;
            hdr_bad_in = 1'b0;
            id_bad_in  = 1'b0;
            len_bad_in = 1'b0;
            value_in   = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 9'd0;
         sum_ff     <= 8'd0;
         hdr_bad_ff <= 1'b0;
         id_bad_ff  <= 1'b0;
         len_bad_ff <= 1'b0;
         value_ff   <= 16'd0;
      end else begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         hdr_bad_ff <= hdr_bad_in;
         id_bad_ff  <= id_bad_in;
         len_bad_ff <= len_bad_in;
         value_ff   <= value_in;
      end
   end

   `SSPC_ASSERT(a_timeout_gives_status, clock, reset, (accept && kind == KIND_TIMEOUT) |-> (result.valid && result.payload.status_code == STATUS_TIMEOUT))
   `SSPC_ASSERT(a_value_only_when_ok, clock, reset, (result.valid && result.payload.status_code != STATUS_OK) |-> (result.payload.reply_value == 16'd0))
   `SSPC_ASSERT(a_result_clears_reply, clock, reset, result.valid |=> (pos_ff == 9'd0 && sum_ff == 8'd0))
   `SSPC_ASSERT_ALWAYS(a_position_bounded, clock, reset || (pos_ff <= POS_MAX))

endmodule
`default_nettype wire

### src/sspc_rsp_buffer.sv
// Two-entry result buffer between the parser and the response channel.
`default_nettype none
`include "servo_status_packet_checker_macros.svh"
module sspc_rsp_buffer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sspc_pkg::result_type    result,
   output logic                         full,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output sspc_pkg::rsp_payload_type    rsp_payload
);
   import sspc_pkg::*;

   rsp_payload_type slot_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff,  count_in;
   logic            push;
   logic            pop;

   assign push = result.valid;
   assign pop  = rsp_valid && !rsp_stall;

   // Track occupancy and pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the result transaction
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= result.payload;
      end
   end

   assign full        = (count_ff == 2'd2);
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = slot_ff[rd_ptr_ff];

   `SSPC_ASSERT(a_no_push_when_full, clock, reset, push |-> !full)
   `SSPC_ASSERT_ALWAYS(a_count_bounded, clock, reset || (count_ff <= 2'd2))
   `SSPC_ASSERT(a_push_grows_count, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))

endmodule
`default_nettype wire

### src/servo_status_packet_checker.sv
// Throughput: one transaction per cycle while req_stall is low. Each result is registered in
// the buffer before rsp_valid; the parser decides in one pass from its state registers.
// A two-entry result buffer keeps req_stall low while one result waits on rsp_stall.
// Reset (synchronous, active high) clears the reply state and the buffer;
// expected_id returns to 0 and expected_length to 2.
`default_nettype none
module servo_status_packet_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status_code,
   output logic [15:0]      rsp_reply_value,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_write_data
);
   import sspc_pkg::*;

   cfg_type         cfg;
   result_type      result;
   rsp_payload_type rsp_payload;
   logic            buffer_full;
   logic            req_accept;

   // Hold the request side only while the result buffer is full
   assign req_stall  = buffer_full;
   assign req_accept = req_valid && !req_stall;

   sspc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   sspc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .accept  (req_accept),
      .kind    (req_kind),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   sspc_rsp_buffer u_rsp_buffer (
      .clock       (clock),
      .reset       (reset),
      .result      (result),
      .full        (buffer_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   assign rsp_status_code = rsp_payload.status_code;
   assign rsp_reply_value = rsp_payload.reply_value;

endmodule
`default_nettype wire

### tb/reply_check_pkg.sv
// Status predictor and scoreboard for the servo status packet checker testbench.
`timescale 1ns / 100ps
package reply_check_pkg;
   import sspc_pkg::*;

   class reply_tracker;
      // register copies
      logic [7:0]      id_setting;
      logic [7:0]      length_setting;
      // reply parsing state
      logic [8:0]      position;
      logic [7:0]      byte_sum;
      bit              header_bad;
      bit              id_bad;
      bit              length_bad;
      logic [15:0]     param_value;
      // statuses waiting for the block to deliver them
      rsp_payload_type pending_status[$];
      int              mismatches;
      int              results_checked;
      int              status_seen[6];

      function new();
         id_setting = EXPECTED_ID_RESET;
         length_setting = EXPECTED_LEN_RESET;
         mismatches = 0;
         results_checked = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         clear_reply();
      endfunction

      function void clear_reply();
         position = '0;
         byte_sum = '0;
         header_bad = 1'b0;
         id_bad = 1'b0;
         length_bad = 1'b0;
         param_value = '0;
      endfunction

      function void set_register(logic index, logic [7:0] data);
         if (index == CSR_EXPECTED_ID) begin
            id_setting = data;
         end else begin
            length_setting = data;
         end
      endfunction

      function int pending_count();
         return pending_status.size();
      endfunction

      function void push_status(status_code_type code, logic [15:0] value);
         rsp_payload_type entry;
         entry.status_code = code;
         entry.reply_value = value;
         pending_status.push_back(entry);
      endfunction

      // Advance the parser by one accepted transaction; queue a status if the reply ends
      function void take_item(logic kind, logic [7:0] rx);
         logic [8:0]      last_pos;
         status_code_type code;
         logic [15:0]     value;
         last_pos = {1'b0, length_setting} + POS_TRAILER;
         value = '0;
         if (kind == KIND_TIMEOUT) begin
            clear_reply();
            push_status(STATUS_TIMEOUT, '0);
         end else if (position < last_pos) begin
            if (position < POS_ID) begin
               if (rx != HEADER_BYTE) header_bad = 1'b1;
            end else begin
               if (position == POS_ID && rx != id_setting) id_bad = 1'b1;
               if (position == POS_LENGTH && rx != length_setting) length_bad = 1'b1;
               if (position == POS_PARAM0) param_value[7:0] = rx;
               if (position == POS_PARAM1) param_value[15:8] = rx;
               byte_sum = byte_sum + rx;
            end
            position = position + 9'd1;
         end else begin
            // byte at or past the last position is the checksum
            if (header_bad) begin
               code = STATUS_BAD_HEADER;
            end else if (id_bad) begin
               code = STATUS_BAD_ID;
            end else if (length_bad) begin
               code = STATUS_BAD_LENGTH;
            end else if (8'(~byte_sum) != rx) begin
               code = STATUS_BAD_CHECKSUM;
            end else begin
               code = STATUS_OK;
               value = param_value;
            end
            clear_reply();
            push_status(code, value);
         end
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH: %s", what);
         mismatches++;
      endtask

      // Compare one delivered status against the oldest expectation
      task match_status(logic [2:0] code, logic [15:0] value);
         rsp_payload_type want;
         if (pending_status.size() == 0) begin
            report_mismatch($sformatf("status %0d value %h with nothing expected",
                                      code, value));
            return;
         end
         want = pending_status.pop_front();
         results_checked++;
         status_seen[int'(want.status_code)]++;
         if (code !== want.status_code)
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      results_checked, code, want.status_code));
         if (value !== want.reply_value)
            report_mismatch($sformatf("result %0d: value %h, expected %h",
                                      results_checked, value, want.reply_value));
      endtask
   endclass

endpackage

### tb/servo_status_packet_checker_test.sv
// Top-level testbench: feeds reply bytes and timeouts to the checker and checks every status.
`timescale 1ns / 100ps
module servo_status_packet_checker_test;
   import sspc_pkg::*;
   import reply_check_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 80;

   typedef enum int {
      FLAW_NONE,
      FLAW_HEADER,
      FLAW_ID,
      FLAW_LENGTH,
      FLAW_CHECKSUM,
      FLAW_CUT
   } reply_flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = KIND_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status_code;
   logic [15:0] rsp_reply_value;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_EXPECTED_ID;
   logic [7:0]  csr_write_data = 8'h00;

   reply_tracker tracker = new();
   int  idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_off = 1'b0;
   int  items_sent = 0;
   int  settings_used = 0;
   int  cycle_count = 0;

   servo_status_packet_checker dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status_code  (rsp_status_code),
      .rsp_reply_value  (rsp_reply_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Stall the result channel at random, or hold it off entirely
   always @(negedge clock) begin
      rsp_stall <= hold_off || (int'($urandom_range(99)) < stall_pct);
   end

   // Check every accepted result transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_status(rsp_status_code, rsp_reply_value);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offer one transaction, idling at random first; return once accepted
   task automatic send_item(input logic kind, input logic [7:0] rx);
      @(negedge clock);
      while (int'($urandom_range(99)) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      tracker.take_item(kind, rx);
      items_sent++;
   endtask

   // Drop valid and wait until every queued status has come back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_count() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [7:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_register(index, data);
   endtask

   // Send one reply sized by the current length setting, with at most one flaw
   task automatic send_reply(input reply_flaw_type flaw);
      int         size;
      int         cut;
      int         bad_hdr;
      int         i;
      logic [7:0] rx;
      logic [7:0] sum;
      size = int'(tracker.length_setting) + 4;
      cut = (flaw == FLAW_CUT) ? int'($urandom_range(size - 1, 1)) : size;
      bad_hdr = $urandom_range(1);
      sum = 8'h00;
      for (i = 0; i < cut; i++) begin
         if (i == size - 1) begin
            rx = ~sum;
            if (flaw == FLAW_CHECKSUM) rx = rx ^ 8'($urandom_range(255, 1));
         end else if (i < 2) begin
            rx = HEADER_BYTE;
            if (flaw == FLAW_HEADER && i == bad_hdr) rx = 8'($urandom_range(254));
         end else if (i == 2) begin
            rx = tracker.id_setting;
            if (flaw == FLAW_ID) rx = rx ^ 8'($urandom_range(255, 1));
         end else if (i == 3) begin
            rx = tracker.length_setting;
            if (flaw == FLAW_LENGTH) rx = rx ^ 8'($urandom_range(255, 1));
         end else begin
            rx = 8'($urandom);
         end
         if (i >= 2) sum = sum + rx;
         send_item(KIND_BYTE, rx);
      end
      if (flaw == FLAW_CUT) send_item(KIND_TIMEOUT, 8'($urandom));
   endtask

   // Mostly well-formed replies, some flawed ones and some loose noise
   task automatic run_random(input int count);
      int             stop_at;
      int             pick;
      reply_flaw_type flaw;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            repeat ($urandom_range(3, 1)) send_item(1'($urandom_range(1)), 8'($urandom));
         end else begin
            // resync with a timeout if a reply is still open
            if (tracker.position != 0) send_item(KIND_TIMEOUT, 8'($urandom));
            if (pick < 60) flaw = FLAW_NONE;
            else if (pick < 68) flaw = FLAW_HEADER;
            else if (pick < 76) flaw = FLAW_ID;
            else if (pick < 84) flaw = FLAW_LENGTH;
            else if (pick < 92) flaw = FLAW_CHECKSUM;
            else flaw = FLAW_CUT;
            send_reply(flaw);
         end
      end
   endtask

   task automatic run_phase(input logic [7:0] id, input logic [7:0] len,
                            input int src_pct, input int rcv_pct, input int count);
      settle();
      write_reg(CSR_EXPECTED_ID, id);
      write_reg(CSR_EXPECTED_LENGTH, len);
      settings_used++;
      idle_pct = src_pct;
      stall_pct = rcv_pct;
      run_random(count);
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // timeout with no reply open, then a clean reply under reset settings
      send_item(KIND_TIMEOUT, 8'hFF);
      send_reply(FLAW_NONE);

      // shortest reply: the length byte position is the checksum
      settle();
      write_reg(CSR_EXPECTED_ID, 8'hFF);
      write_reg(CSR_EXPECTED_LENGTH, 8'h00);
      send_reply(FLAW_NONE);
      send_reply(FLAW_HEADER);

      // shrink the length mid-reply so the next byte ends it
      settle();
      write_reg(CSR_EXPECTED_ID, 8'h5A);
      write_reg(CSR_EXPECTED_LENGTH, 8'h04);
      send_item(KIND_BYTE, HEADER_BYTE);
      send_item(KIND_BYTE, HEADER_BYTE);
      send_item(KIND_BYTE, 8'h5A);
      send_item(KIND_BYTE, 8'h04);
      settle();
      write_reg(CSR_EXPECTED_LENGTH, 8'h00);
      send_item(KIND_BYTE, 8'(~(8'h5A + 8'h04)));

      // abort a reply part way
      settle();
      write_reg(CSR_EXPECTED_LENGTH, 8'h01);
      send_item(KIND_BYTE, HEADER_BYTE);
      send_item(KIND_BYTE, HEADER_BYTE);
      send_item(KIND_BYTE, 8'h5A);
      send_item(KIND_TIMEOUT, 8'h00);
      settings_used += 4;

      // random phases across idling modes and register settings
      run_phase(8'($urandom), 8'd2, 0, 0, 150);
      run_phase(8'hFF, 8'd0, 49, 0, 120);
      run_phase(8'h00, 8'd1, 0, 49, 120);
      run_phase(8'($urandom), 8'($urandom_range(12, 3)), 18, 18, 150);

      // hold off results long enough to back up the input channel
      settle();
      write_reg(CSR_EXPECTED_LENGTH, 8'($urandom_range(6, 2)));
      settings_used++;
      idle_pct = 0;
      stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end
         repeat (30) send_item(KIND_TIMEOUT, 8'($urandom));
      join
      run_random(60);

      // longest replies
      run_phase(8'($urandom), 8'hFF, 18, 18, 450);

      settle();
      $display("Sent %0d transactions over %0d register settings; %0d statuses checked.",
               items_sent, settings_used, tracker.results_checked);
      $display("Statuses: ok %0d, timeout %0d, header %0d, id %0d, length %0d, checksum %0d",
               tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
               tracker.status_seen[3], tracker.status_seen[4], tracker.status_seen[5]);
      if (tracker.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
